// ===== rtl/line_follow_pd_steering_unit_assert.svh =====
// Assertion macros used by the checker of the steering unit.
`ifndef LINE_FOLLOW_PD_STEERING_UNIT_ASSERT_SVH
`define LINE_FOLLOW_PD_STEERING_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define LFPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define LFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lfpd_pkg.sv =====
`default_nettype none

package lfpd_pkg;

    localparam int DEF_SAMPLE_BITS = 10;
    localparam int DEF_SPEED_BITS  = 8;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SET_POINT      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP_SPEED      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_THRESHOLD = 3'd3;

    localparam int RST_SET_POINT      = 512;
    localparam int RST_TOP_SPEED      = 200;
    localparam int RST_LOW_THRESHOLD  = 103;
    localparam int RST_HIGH_THRESHOLD = 972;

    localparam int CROSS_SLOWDOWN = 25;

    typedef logic [1:0] t_zone;

    localparam t_zone ZONE_OFF   = 2'd0;
    localparam t_zone ZONE_CROSS = 2'd1;
    localparam t_zone ZONE_TRACK = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/line_follow_pd_steering_unit.sv =====
`default_nettype none

// PD steering for a line-following differential-drive robot. Each input beat
// carries one line-sensor sample; each output beat carries the zone (off line,
// cross line, tracking), the two motor directions and the two motor speeds.
// One sample is taken every clock cycle when the output side keeps up. Each
// sample passes the input register, then the result register, before its
// result is presented on the output. The previous error and the directions
// close their loop in the single logic step between those registers, so
// back-to-back samples see each other's state. Configuration is written
// through its own channel, which is always ready; indexes 0..3 are set_point,
// top_speed, low_threshold and high_threshold, other indexes are ignored, and
// the user must make writes only while idle, which the block does not enforce.
module line_follow_pd_steering_unit
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int SPEED_BITS  = DEF_SPEED_BITS,
    localparam int CfgBits = (SAMPLE_BITS > SPEED_BITS) ? SAMPLE_BITS : SPEED_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CfgBits-1:0]      i_cfg_data,

    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample,

    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_zone,
    output logic                         o_left_forward,
    output logic                         o_right_forward,
    output logic [SPEED_BITS-1:0]        o_left_speed,
    output logic [SPEED_BITS-1:0]        o_right_speed
);

    localparam int TermBits = (SAMPLE_BITS + 7 > SPEED_BITS + 3) ?
                              SAMPLE_BITS + 7 : SPEED_BITS + 3;

    localparam logic [SAMPLE_BITS-1:0] SetPointRst = SAMPLE_BITS'(RST_SET_POINT);
    localparam logic [SPEED_BITS-1:0]  TopSpeedRst = SPEED_BITS'(RST_TOP_SPEED);
    localparam logic [SAMPLE_BITS-1:0] LowThrRst   = SAMPLE_BITS'(RST_LOW_THRESHOLD);
    localparam logic [SAMPLE_BITS-1:0] HighThrRst  = SAMPLE_BITS'(RST_HIGH_THRESHOLD);
    localparam logic [SPEED_BITS-1:0]  CrossSlow   = SPEED_BITS'(CROSS_SLOWDOWN);

    logic [SAMPLE_BITS-1:0] r_set_point;
    logic [SPEED_BITS-1:0]  r_top_speed;
    logic [SAMPLE_BITS-1:0] r_low_thr;
    logic [SAMPLE_BITS-1:0] r_high_thr;

    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_sample;

    logic signed [SAMPLE_BITS:0] r_last_error;
    logic                        r_left_dir;
    logic                        r_right_dir;

    logic                  r_out_valid;
    t_zone                 r_zone;
    logic                  r_left_fwd;
    logic                  r_right_fwd;
    logic [SPEED_BITS-1:0] r_left_speed;
    logic [SPEED_BITS-1:0] r_right_speed;

    logic                  move;
    logic                  in_beat;

    t_zone                 n_zone;
    logic                  n_left_dir;
    logic                  n_right_dir;
    logic [SPEED_BITS-1:0] n_left_speed;
    logic [SPEED_BITS-1:0] n_right_speed;

    logic signed [TermBits-1:0] s_w;
    logic signed [TermBits-1:0] sp_w;
    logic signed [TermBits-1:0] le_w;
    logic signed [TermBits-1:0] p_w;
    logic signed [TermBits-1:0] d_w;
    logic signed [TermBits-1:0] sum_w;
    logic signed [TermBits-1:0] t_w;
    logic signed [TermBits-1:0] m_w;
    logic signed [TermBits-1:0] m2_w;
    logic signed [TermBits-1:0] ls_w;
    logic signed [TermBits-1:0] rs_w;
    logic [SPEED_BITS-1:0]      cross_speed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_point <= SetPointRst;
            r_top_speed <= TopSpeedRst;
            r_low_thr   <= LowThrRst;
            r_high_thr  <= HighThrRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SET_POINT:      r_set_point <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_TOP_SPEED:      r_top_speed <= i_cfg_data[SPEED_BITS-1:0];
                REG_LOW_THRESHOLD:  r_low_thr   <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_HIGH_THRESHOLD: r_high_thr  <= i_cfg_data[SAMPLE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign move       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || move;
    assign in_beat    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_sample <= i_sample;
        end
    end

    assign s_w   = $signed({{(TermBits-SAMPLE_BITS){1'b0}}, r_sample});
    assign sp_w  = $signed({{(TermBits-SAMPLE_BITS){1'b0}}, r_set_point});
    assign le_w  = TermBits'(r_last_error);
    assign p_w   = s_w - sp_w;
    assign d_w   = p_w - le_w;
    assign sum_w = (p_w <<< 1) + p_w + (d_w <<< 3) + (d_w <<< 1);
    assign t_w   = (sum_w + $signed({{(TermBits-1){1'b0}}, sum_w[TermBits-1]})) >>> 1;
    assign m_w   = $signed({{(TermBits-SPEED_BITS){1'b0}}, r_top_speed});
    assign m2_w  = m_w <<< 1;

    assign cross_speed = (r_top_speed >= CrossSlow) ? (r_top_speed - CrossSlow) : '0;

    always_comb begin
        if (t_w > m_w) begin
            n_left_dir  = 1'b1;
            n_right_dir = 1'b0;
            ls_w        = m_w;
            rs_w        = (t_w < m2_w) ? (t_w - m_w) : m_w;
        end else if (t_w < -m_w) begin
            n_left_dir  = 1'b0;
            n_right_dir = 1'b1;
            rs_w        = m_w;
            ls_w        = (t_w > -m2_w) ? (-m_w - t_w) : m_w;
        end else begin
            n_left_dir  = 1'b1;
            n_right_dir = 1'b1;
            if (t_w > 0) begin
                ls_w = m_w;
                rs_w = m_w - t_w;
            end else begin
                ls_w = m_w + t_w;
                rs_w = m_w;
            end
        end
    end

    always_comb begin
        priority if (r_sample < r_low_thr) begin
            n_zone        = ZONE_OFF;
            n_left_speed  = '0;
            n_right_speed = '0;
        end else if (r_sample > r_high_thr) begin
            n_zone        = ZONE_CROSS;
            n_left_speed  = cross_speed;
            n_right_speed = cross_speed;
        end else begin
            n_zone        = ZONE_TRACK;
            n_left_speed  = ls_w[SPEED_BITS-1:0];
            n_right_speed = rs_w[SPEED_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_left_dir   <= 1'b1;
            r_right_dir  <= 1'b1;
        end else if (move && (n_zone == ZONE_TRACK)) begin
            r_last_error <= p_w[SAMPLE_BITS:0];
            r_left_dir   <= n_left_dir;
            r_right_dir  <= n_right_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_zone        <= n_zone;
            r_left_speed  <= n_left_speed;
            r_right_speed <= n_right_speed;
            if (n_zone == ZONE_TRACK) begin
                r_left_fwd  <= n_left_dir;
                r_right_fwd <= n_right_dir;
            end else begin
                r_left_fwd  <= r_left_dir;
                r_right_fwd <= r_right_dir;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_zone          = r_zone;
    assign o_left_forward  = r_left_fwd;
    assign o_right_forward = r_right_fwd;
    assign o_left_speed    = r_left_speed;
    assign o_right_speed   = r_right_speed;

endmodule

`default_nettype wire

// ===== rtl/lfpd_checker.sv =====
`default_nettype none

`include "line_follow_pd_steering_unit_assert.svh"

module lfpd_checker
    import lfpd_pkg::*;
#(
    parameter int SPEED_BITS = DEF_SPEED_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  o_in_ready,
    input  wire logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [1:0]            o_zone,
    input  wire logic                  o_left_forward,
    input  wire logic                  o_right_forward,
    input  wire logic [SPEED_BITS-1:0] o_left_speed,
    input  wire logic [SPEED_BITS-1:0] o_right_speed
);

    `LFPD_ASSERT_NOW(a_off_line_stops, o_out_valid && (o_zone == ZONE_OFF),
        (o_left_speed == '0) && (o_right_speed == '0), "off-line beat with nonzero speed")

    `LFPD_ASSERT_NOW(a_cross_even, o_out_valid && (o_zone == ZONE_CROSS),
        o_left_speed == o_right_speed, "cross-line beat with unequal speeds")

    `LFPD_ASSERT_NOW(a_never_both_back, o_out_valid,
        o_left_forward || o_right_forward, "both motors reported backward")

    `LFPD_ASSERT_NOW(a_in_ready_free, !o_out_valid || i_out_ready,
        o_in_ready, "input held off while the result side was free")

    `LFPD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_zone) && $stable(o_left_speed) && $stable(o_right_speed)
            && $stable(o_left_forward) && $stable(o_right_forward),
        "stalled result beat changed")

endmodule

bind line_follow_pd_steering_unit lfpd_checker #(
    .SPEED_BITS(SPEED_BITS)
) u_lfpd_checker (.*);

`default_nettype wire
